// File: src/ervr_pkg.sv
// ----------------------------------------------------------------------------
// ervr_pkg
// Shared types, widths and trig tables for the euler xyz vector rotator.
// ----------------------------------------------------------------------------
package ervr_pkg;

    localparam int VEC_W        = 32;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int TRIG_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TRIG_W       = 34;
    localparam int PROD_W       = VEC_W + TRIG_W;
    localparam int SUM_W        = PROD_W + 1;

    localparam logic signed [TRIG_W-1:0] GAIN_INV = TRIG_W'(652032874);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [VEC_W-1:0]  t_comp;
    typedef logic signed [TRIG_W-1:0] t_trig_word;

    typedef struct packed {
        t_trig_word x;
        t_trig_word y;
        t_trig_word z;
    } t_cordic;

    typedef struct packed {
        t_trig_word c;
        t_trig_word s;
    } t_cs;

    typedef struct packed {
        t_comp [2:0]      v;
        logic [2:0][1:0]  quad;
        logic [2:0]       nz;
    } t_item;

    function automatic t_trig_word atan_turn(input logic [STEP_W-1:0] i);
        t_trig_word r;
        case (i)
            5'd0:  r = TRIG_W'(32'h20000000);
            5'd1:  r = TRIG_W'(32'h12E4051E);
            5'd2:  r = TRIG_W'(32'h09FB385B);
            5'd3:  r = TRIG_W'(32'h051111D4);
            5'd4:  r = TRIG_W'(32'h028B0D43);
            5'd5:  r = TRIG_W'(32'h0145D7E1);
            5'd6:  r = TRIG_W'(32'h00A2F61E);
            5'd7:  r = TRIG_W'(32'h00517C55);
            5'd8:  r = TRIG_W'(32'h0028BE53);
            5'd9:  r = TRIG_W'(32'h00145F2F);
            5'd10: r = TRIG_W'(32'h000A2F98);
            5'd11: r = TRIG_W'(32'h000517CC);
            5'd12: r = TRIG_W'(32'h00028BE6);
            5'd13: r = TRIG_W'(32'h000145F3);
            5'd14: r = TRIG_W'(32'h0000A2F9);
            5'd15: r = TRIG_W'(32'h0000517D);
            5'd16: r = TRIG_W'(32'h000028BE);
            5'd17: r = TRIG_W'(32'h0000145F);
            5'd18: r = TRIG_W'(32'h00000A30);
            5'd19: r = TRIG_W'(32'h00000518);
            5'd20: r = TRIG_W'(32'h0000028C);
            5'd21: r = TRIG_W'(32'h00000146);
            5'd22: r = TRIG_W'(32'h000000A3);
            5'd23: r = TRIG_W'(32'h00000051);
            5'd24: r = TRIG_W'(32'h00000029);
            5'd25: r = TRIG_W'(32'h00000014);
            5'd26: r = TRIG_W'(32'h0000000A);
            5'd27: r = TRIG_W'(32'h00000005);
            5'd28: r = TRIG_W'(32'h00000003);
            5'd29: r = TRIG_W'(32'h00000001);
            default: r = '0;
        endcase
        return r;
    endfunction

    // first and second component of the pair turned about an axis
    function automatic logic [1:0] pair_p(input logic [1:0] axis);
        logic [1:0] r;
        case (axis)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_q(input logic [1:0] axis);
        logic [1:0] r;
        case (axis)
            AXIS_X:  r = AXIS_Z;
            AXIS_Y:  r = AXIS_X;
            default: r = AXIS_Y;
        endcase
        return r;
    endfunction

    function automatic t_comp sat32(input logic signed [SUM_W-1:0] v);
        t_comp r;
        if (v > SUM_W'(signed'(33'sh0_7FFF_FFFF))) begin
            r = {1'b0, {(VEC_W-1){1'b1}}};
        end else if (v < SUM_W'(signed'(33'sh1_8000_0000))) begin
            r = {1'b1, {(VEC_W-1){1'b0}}};
        end else begin
            r = v[VEC_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/ervr_if.sv
// ----------------------------------------------------------------------------
// ervr interfaces
// Valid/ready channels for input vectors with angles and rotated vectors.
// ----------------------------------------------------------------------------
interface ervr_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ervr_pkg::VEC_W-1:0] vec_x;
    logic signed [ervr_pkg::VEC_W-1:0] vec_y;
    logic signed [ervr_pkg::VEC_W-1:0] vec_z;
    logic [ervr_pkg::ANGLE_W-1:0]      turn_x;
    logic [ervr_pkg::ANGLE_W-1:0]      turn_y;
    logic [ervr_pkg::ANGLE_W-1:0]      turn_z;

    modport source (output valid, vec_x, vec_y, vec_z, turn_x, turn_y, turn_z,
                    input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, turn_x, turn_y, turn_z,
                  output ready);
endinterface

interface ervr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ervr_pkg::VEC_W-1:0] out_x;
    logic signed [ervr_pkg::VEC_W-1:0] out_y;
    logic signed [ervr_pkg::VEC_W-1:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// File: src/euler_xyz_vector_rotation_core.sv
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation_core
// Rotates a q16.16 vector about x, then y, then z by turn-fraction angles.
// ----------------------------------------------------------------------------
// pipeline: 30 cordic cells, 1 quadrant map stage, 3 x 2 rotation stages
// throughput: one beat per cycle; the whole pipeline holds while the output
// beat is not taken
// reset: synchronous active low, clears every valid bit; data is not reset
module euler_xyz_vector_rotation_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ervr_in_if.sink       i_in,
    ervr_out_if.source    o_out
);
    localparam int N = ervr_pkg::CORDIC_STEPS;

    logic                    w_en;
    logic                    w_valid  [0:N];
    ervr_pkg::t_item         w_item   [0:N];
    ervr_pkg::t_cordic [2:0] w_cordic [0:N];
    logic [2:0][31:0]        w_turn;

    logic                r_map_valid;
    ervr_pkg::t_item     r_map_item;
    ervr_pkg::t_cs [2:0] r_map_cs;
    ervr_pkg::t_cs [2:0] n_map_cs;

    logic                w_rv  [0:3];
    ervr_pkg::t_item     w_ri  [0:3];
    ervr_pkg::t_cs [2:0] w_rcs [0:3];

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_turn[0] = {i_in.turn_x[ervr_pkg::ANGLE_BITS-1:0], {(32-ervr_pkg::ANGLE_BITS){1'b0}}};
    assign w_turn[1] = {i_in.turn_y[ervr_pkg::ANGLE_BITS-1:0], {(32-ervr_pkg::ANGLE_BITS){1'b0}}};
    assign w_turn[2] = {i_in.turn_z[ervr_pkg::ANGLE_BITS-1:0], {(32-ervr_pkg::ANGLE_BITS){1'b0}}};

    always_comb begin
        w_valid[0]       = i_in.valid;
        w_item[0].v[0]   = i_in.vec_x;
        w_item[0].v[1]   = i_in.vec_y;
        w_item[0].v[2]   = i_in.vec_z;
        for (int k = 0; k < 3; k++) begin
            w_item[0].quad[k]   = w_turn[k][31:30];
            w_item[0].nz[k]     = |w_turn[k];
            w_cordic[0][k].x    = ervr_pkg::GAIN_INV;
            w_cordic[0][k].y    = '0;
            w_cordic[0][k].z    = ervr_pkg::TRIG_W'(w_turn[k][29:0]);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        ervr_cordic_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_step   (ervr_pkg::STEP_W'(g)),
            .i_valid  (w_valid[g]),
            .i_item   (w_item[g]),
            .i_cordic (w_cordic[g]),
            .o_valid  (w_valid[g+1]),
            .o_item   (w_item[g+1]),
            .o_cordic (w_cordic[g+1])
        );
    end

    // quadrant fold by exact negation and swap
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (w_item[N].quad[k])
                ervr_pkg::QUAD_0: begin
                    n_map_cs[k].c = w_cordic[N][k].x;
                    n_map_cs[k].s = w_cordic[N][k].y;
                end
                ervr_pkg::QUAD_1: begin
                    n_map_cs[k].c = -w_cordic[N][k].y;
                    n_map_cs[k].s = w_cordic[N][k].x;
                end
                ervr_pkg::QUAD_2: begin
                    n_map_cs[k].c = -w_cordic[N][k].x;
                    n_map_cs[k].s = -w_cordic[N][k].y;
                end
                default: begin
                    n_map_cs[k].c = w_cordic[N][k].y;
                    n_map_cs[k].s = -w_cordic[N][k].x;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
        end else if (w_en) begin
            r_map_valid <= w_valid[N];
        end
        if (w_en) begin
            r_map_item <= w_item[N];
            r_map_cs   <= n_map_cs;
        end
    end

    assign w_rv[0]  = r_map_valid;
    assign w_ri[0]  = r_map_item;
    assign w_rcs[0] = r_map_cs;

    for (genvar a = 0; a < 3; a++) begin : g_rot
        ervr_rot_stage u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_axis  (2'(a)),
            .i_valid (w_rv[a]),
            .i_item  (w_ri[a]),
            .i_cs    (w_rcs[a]),
            .o_valid (w_rv[a+1]),
            .o_item  (w_ri[a+1]),
            .o_cs    (w_rcs[a+1])
        );
    end

    assign o_out.valid = w_rv[3];
    assign o_out.out_x = w_ri[3].v[0];
    assign o_out.out_y = w_ri[3].v[1];
    assign o_out.out_z = w_ri[3].v[2];
endmodule

// File: src/ervr_cordic_cell.sv
// ----------------------------------------------------------------------------
// ervr_cordic_cell
// One cordic iteration for all three angles, carrying the vector along.
// ----------------------------------------------------------------------------
module ervr_cordic_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [ervr_pkg::STEP_W-1:0]       i_step,
    input  logic                              i_valid,
    input  ervr_pkg::t_item                   i_item,
    input  ervr_pkg::t_cordic [2:0]           i_cordic,
    output logic                              o_valid,
    output ervr_pkg::t_item                   o_item,
    output ervr_pkg::t_cordic [2:0]           o_cordic
);
    logic                    r_valid;
    ervr_pkg::t_item         r_item;
    ervr_pkg::t_cordic [2:0] r_cordic;
    ervr_pkg::t_cordic [2:0] n_cordic;
    ervr_pkg::t_trig_word    w_atan;

    assign w_atan = ervr_pkg::atan_turn(i_step);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ervr_pkg::t_trig_word dx;
            ervr_pkg::t_trig_word dy;
            dx = $signed(i_cordic[k].y) >>> i_step;
            dy = $signed(i_cordic[k].x) >>> i_step;
            if (!i_cordic[k].z[ervr_pkg::TRIG_W-1]) begin
                n_cordic[k].x = i_cordic[k].x - dx;
                n_cordic[k].y = i_cordic[k].y + dy;
                n_cordic[k].z = i_cordic[k].z - w_atan;
            end else begin
                n_cordic[k].x = i_cordic[k].x + dx;
                n_cordic[k].y = i_cordic[k].y - dy;
                n_cordic[k].z = i_cordic[k].z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item   <= i_item;
            r_cordic <= n_cordic;
        end
    end

    assign o_valid  = r_valid;
    assign o_item   = r_item;
    assign o_cordic = r_cordic;
endmodule

// File: src/ervr_rot_stage.sv
// ----------------------------------------------------------------------------
// ervr_rot_stage
// Rotates one component pair about an axis: multiply, then round and saturate.
// ----------------------------------------------------------------------------
module ervr_rot_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [1:0]              i_axis,
    input  logic                    i_valid,
    input  ervr_pkg::t_item         i_item,
    input  ervr_pkg::t_cs [2:0]     i_cs,
    output logic                    o_valid,
    output ervr_pkg::t_item         o_item,
    output ervr_pkg::t_cs [2:0]     o_cs
);
    logic [1:0] w_pi;
    logic [1:0] w_qi;
    logic signed [ervr_pkg::VEC_W-1:0]  w_p;
    logic signed [ervr_pkg::VEC_W-1:0]  w_q;
    logic signed [ervr_pkg::TRIG_W-1:0] w_c;
    logic signed [ervr_pkg::TRIG_W-1:0] w_s;

    logic                              r1_valid;
    ervr_pkg::t_item                   r1_item;
    ervr_pkg::t_cs [2:0]               r1_cs;
    logic signed [ervr_pkg::PROD_W-1:0] r1_pc;
    logic signed [ervr_pkg::PROD_W-1:0] r1_qs;
    logic signed [ervr_pkg::PROD_W-1:0] r1_qc;
    logic signed [ervr_pkg::PROD_W-1:0] r1_ps;

    logic signed [ervr_pkg::SUM_W-1:0] w_sum_p;
    logic signed [ervr_pkg::SUM_W-1:0] w_sum_q;
    ervr_pkg::t_item                   n_item;

    logic                r2_valid;
    ervr_pkg::t_item     r2_item;
    ervr_pkg::t_cs [2:0] r2_cs;

    assign w_pi = ervr_pkg::pair_p(i_axis);
    assign w_qi = ervr_pkg::pair_q(i_axis);
    assign w_p  = $signed(i_item.v[w_pi]);
    assign w_q  = $signed(i_item.v[w_qi]);
    assign w_c  = $signed(i_cs[i_axis].c);
    assign w_s  = $signed(i_cs[i_axis].s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r1_item <= i_item;
            r1_cs   <= i_cs;
            r1_pc   <= w_p * w_c;
            r1_qs   <= w_q * w_s;
            r1_qc   <= w_q * w_c;
            r1_ps   <= w_p * w_s;
            r2_item <= n_item;
            r2_cs   <= r1_cs;
        end
    end

    // round to nearest from q30, ties up
    always_comb begin
        w_sum_p = ervr_pkg::SUM_W'(r1_pc) - ervr_pkg::SUM_W'(r1_qs)
                + (ervr_pkg::SUM_W'(1) <<< (ervr_pkg::TRIG_FRAC - 1));
        w_sum_q = ervr_pkg::SUM_W'(r1_qc) + ervr_pkg::SUM_W'(r1_ps)
                + (ervr_pkg::SUM_W'(1) <<< (ervr_pkg::TRIG_FRAC - 1));
        n_item = r1_item;
        if (r1_item.nz[i_axis]) begin
            n_item.v[ervr_pkg::pair_p(i_axis)] = ervr_pkg::sat32(w_sum_p >>> ervr_pkg::TRIG_FRAC);
            n_item.v[ervr_pkg::pair_q(i_axis)] = ervr_pkg::sat32(w_sum_q >>> ervr_pkg::TRIG_FRAC);
        end
    end

    assign o_valid = r2_valid;
    assign o_item  = r2_item;
    assign o_cs    = r2_cs;
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the euler xyz rotator against a bit-exact cordic rotation predictor,
// with bursty input beats and a stalling output side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ervr_pkg::t_comp              x;
        ervr_pkg::t_comp              y;
        ervr_pkg::t_comp              z;
        logic [ervr_pkg::ANGLE_W-1:0] ax;
        logic [ervr_pkg::ANGLE_W-1:0] ay;
        logic [ervr_pkg::ANGLE_W-1:0] az;
    } t_vec_turn;

    typedef struct packed {
        ervr_pkg::t_comp x;
        ervr_pkg::t_comp y;
        ervr_pkg::t_comp z;
    } t_rot_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    ervr_in_if  in_ch();
    ervr_out_if out_ch();

    euler_xyz_vector_rotation_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_vec_turn pending_q[$];
    t_rot_vec  rotated_q[$];
    int        mismatches = 0;
    bit        hold_off = 1'b0;
    bit        stim_done = 1'b0;
    bit        in_taken = 1'b0;

    localparam longint ATAN_TBL[ervr_pkg::CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

    // arithmetic shift of a signed longint is floor division
    function automatic void sin_cos(input logic [ervr_pkg::ANGLE_W-1:0] a,
                                    output longint c, output longint s);
        logic [31:0] frac;
        longint cx, cy, cz, dx, dy;
        frac = {a, 16'h0};
        cx = 652032874;
        cy = 0;
        cz = longint'(frac[29:0]);
        for (int i = 0; i < ervr_pkg::CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx; cy += dy; cz -= ATAN_TBL[i];
            end else begin
                cx += dx; cy -= dy; cz += ATAN_TBL[i];
            end
        end
        case (frac[31:30])
            ervr_pkg::QUAD_0: begin c = cx;  s = cy;  end
            ervr_pkg::QUAD_1: begin c = -cy; s = cx;  end
            ervr_pkg::QUAD_2: begin c = -cx; s = -cy; end
            default:          begin c = cy;  s = -cx; end
        endcase
    endfunction

    function automatic longint mix_round(input longint a, b, c, s);
        longint sum;
        sum = (a * c - b * s + (64'sd1 <<< 29)) >>> 30;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum;
    endfunction

    function automatic void turn_pair(inout longint p, inout longint q,
                                      input logic [ervr_pkg::ANGLE_W-1:0] a);
        longint c, s, np;
        if (a == '0) return;
        sin_cos(a, c, s);
        np = mix_round(p, q, c, s);
        q = mix_round(q, -p, c, s);
        p = np;
    endfunction

    function automatic t_rot_vec rotate_xyz(input t_vec_turn v);
        longint x, y, z;
        t_rot_vec r;
        x = v.x; y = v.y; z = v.z;
        turn_pair(y, z, v.ax);
        turn_pair(z, x, v.ay);
        turn_pair(x, y, v.az);
        r.x = ervr_pkg::t_comp'(x);
        r.y = ervr_pkg::t_comp'(y);
        r.z = ervr_pkg::t_comp'(z);
        return r;
    endfunction

    function automatic ervr_pkg::t_comp rand_comp();
        case ($urandom_range(0, 5))
            0:       return ervr_pkg::t_comp'(32'h7FFFFFFF - $urandom_range(0, 3));
            1:       return ervr_pkg::t_comp'(32'h80000000 + $urandom_range(0, 3));
            2:       return ervr_pkg::t_comp'($urandom_range(0, 1 << 20))
                            - ervr_pkg::t_comp'(1 << 19);
            default: return ervr_pkg::t_comp'($urandom);
        endcase
    endfunction

    function automatic logic [ervr_pkg::ANGLE_W-1:0] rand_turn();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ervr_pkg::ANGLE_W'($urandom_range(0, 3)) << 14;
            2:       return ervr_pkg::ANGLE_W'(16'h4000 + $urandom_range(0, 4) - 2);
            default: return ervr_pkg::ANGLE_W'($urandom);
        endcase
    endfunction

    function automatic void push_item(input ervr_pkg::t_comp x, y, z,
                                      input logic [ervr_pkg::ANGLE_W-1:0] ax, ay, az);
        t_vec_turn v;
        v = '{x, y, z, ax, ay, az};
        pending_q.push_back(v);
    endfunction

    // input beat taken at this rising edge
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    // sender: bursts and gaps, inputs change on the falling edge
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            // the previous beat, if any, was taken at the last rising edge
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_q.size() == 0 || hold_off) begin
                in_ch.valid <= 1'b0;
            end else begin
                t_vec_turn v;
                v = pending_q.pop_front();
                rotated_q.push_back(rotate_xyz(v));
                in_ch.valid <= 1'b1;
                in_ch.vec_x <= v.x; in_ch.vec_y <= v.y; in_ch.vec_z <= v.z;
                in_ch.turn_x <= v.ax; in_ch.turn_y <= v.ay; in_ch.turn_z <= v.az;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern: periods of steady ready and of random stalls
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 100)
            out_ch.ready <= 1'b1;
        else if (stall_phase < 200)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            out_ch.ready <= ($urandom_range(0, 2) == 0);
    end

    // monitor: compares each accepted output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rotated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: x=%0d y=%0d z=%0d",
                             out_ch.out_x, out_ch.out_y, out_ch.out_z);
            end else begin
                t_rot_vec e;
                e = rotated_q.pop_front();
                if (out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
                    out_ch.out_z !== e.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 e.x, e.y, e.z,
                                 out_ch.out_x, out_ch.out_y, out_ch.out_z);
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
        in_ch.turn_x = '0; in_ch.turn_y = '0; in_ch.turn_z = '0;
        out_ch.ready = 1'b0;
        // directed: zero angles, quadrants, extremes, saturation
        push_item(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);
        push_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h2000, 16'h2000, 16'h2000);
        push_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'h2000, 16'h2000, 16'h2000);
        push_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'hE000, 16'h6000, 16'hA000);
        push_item(32'sh00010000, 0, 0, 16'h4000, 0, 0);
        push_item(0, 32'sh00010000, 0, 16'h8000, 0, 0);
        push_item(0, 0, 32'sh00010000, 16'hC000, 0, 0);
        push_item(32'sh00010000, 0, 0, 0, 16'h4000, 0);
        push_item(32'sh00010000, 0, 0, 0, 0, 16'h4000);
        push_item(32'sh00010000, 32'sh00010000, 32'sh00010000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(32'sh00010000, 32'sh00010000, 32'sh00010000, 16'h0001, 16'h0001, 16'h0001);
        push_item(32'sh7FFFFFFF, 32'sh80000000, 0, 16'h5555, 16'hAAAA, 16'h1234);
        push_item(-1, -1, -1, 16'h8000, 16'h8000, 16'h8000);
        push_item(1, 1, 1, 16'h4000, 16'hC000, 16'h8000);
        push_item(32'sh12345678, 32'shEDCBA987, 32'sh0F0F0F0F, 16'h7FFF, 16'h8001, 16'h3FFF);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        for (int i = 0; i < 550; i++)
            push_item(rand_comp(), rand_comp(), rand_comp(),
                      rand_turn(), rand_turn(), rand_turn());
        // drain fully once midway
        wait (pending_q.size() < 300);
        hold_off = 1'b1;
        wait (rotated_q.size() == 0);
        @(negedge i_clk) hold_off = 1'b0;
        wait (pending_q.size() == 0 && !in_ch.valid);
        wait (rotated_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && rotated_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
